[rtl/core/set_assoc_lru_cache_tags_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag store
// Concurrent checks on the core clock; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define SLC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("slc: assertion failed");
// expression must never be true outside reset
`define SLC_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("slc: forbidden condition seen");
`else
`define SLC_ASSERT(lbl, clk, rstn, prop)
`define SLC_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[rtl/core/slc_pkg.sv]
// ----------------------------------------------------------------------------
// slc_pkg
// Types and constants shared by the cache tag store modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

    localparam int MAX_SETS   = 1024;
    localparam int MAX_WAYS   = 8;
    localparam int SET_W      = $clog2(MAX_SETS);
    localparam int WAY_W      = $clog2(MAX_WAYS);
    localparam int SLOT_W     = SET_W + WAY_W;
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int STAMP_W    = 64;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    // largest index bit count with 2^b <= MAX_SETS
    localparam logic [CFG_W-1:0] IDX_BITS_LIM = CFG_W'(SET_W);
    localparam logic [CFG_W-1:0] WAYS_MAX     = CFG_W'(MAX_WAYS);

    localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd6;
    localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 4'd6;
    localparam logic [CFG_W-1:0] RST_WAYS        = 4'd4;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_ISSUE  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_UPDATE = 6'b010000,
        S_OUT    = 6'b100000
    } slc_state_t;

    // running outcome of the way scan, including the way being compared
    typedef struct packed {
        logic             hit;
        logic             have_empty;
        logic [WAY_W-1:0] empty_way;
        logic [WAY_W-1:0] lru_way;
    } slc_scan_t;

    // tag/stamp array write
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [TAG_W-1:0]  tag;
        logic [STAMP_W-1:0] stamp;
    } slc_line_wr_t;

    // valid row write
    typedef struct packed {
        logic                we;
        logic [SET_W-1:0]    row;
        logic [MAX_WAYS-1:0] bits;
    } slc_vrow_wr_t;

endpackage

`default_nettype wire

[rtl/core/slc_store.sv]
// ----------------------------------------------------------------------------
// slc_store
// Tag, stamp and valid arrays; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_store (
    input  wire logic                           aclk,
    input  wire slc_pkg::slc_line_wr_t          line_wr,
    input  wire logic [slc_pkg::SLOT_W-1:0]     line_raddr,
    output logic      [slc_pkg::TAG_W-1:0]      line_tag_rd,
    output logic      [slc_pkg::STAMP_W-1:0]    line_stamp_rd,
    input  wire slc_pkg::slc_vrow_wr_t          vrow_wr,
    input  wire logic [slc_pkg::SET_W-1:0]      vrow_raddr,
    output logic      [slc_pkg::MAX_WAYS-1:0]   vrow_rd
);
    import slc_pkg::*;

    localparam int SLOTS = MAX_SETS * MAX_WAYS;

    logic [TAG_W-1:0]    tag_mem   [SLOTS];
    logic [STAMP_W-1:0]  stamp_mem [SLOTS];
    logic [MAX_WAYS-1:0] valid_mem [MAX_SETS];

    always_ff @(posedge aclk) begin
        if (line_wr.we) begin
            tag_mem[line_wr.addr]   <= line_wr.tag;
            stamp_mem[line_wr.addr] <= line_wr.stamp;
        end
        line_tag_rd   <= tag_mem[line_raddr];
        line_stamp_rd <= stamp_mem[line_raddr];
    end

    always_ff @(posedge aclk) begin
        if (vrow_wr.we) begin
            valid_mem[vrow_wr.row] <= vrow_wr.bits;
        end
        vrow_rd <= valid_mem[vrow_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/slc_way_cmp.sv]
// ----------------------------------------------------------------------------
// slc_way_cmp
// Shared per-way compare unit: tag match, oldest-stamp and first-empty tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_way_cmp (
    input  wire logic                        aclk,
    input  wire logic                        clr,
    input  wire logic                        step,
    input  wire logic [slc_pkg::WAY_W-1:0]   way,
    input  wire logic                        line_valid,
    input  wire logic [slc_pkg::TAG_W-1:0]   line_tag,
    input  wire logic [slc_pkg::STAMP_W-1:0] line_stamp,
    input  wire logic [slc_pkg::TAG_W-1:0]   key_tag,
    output slc_pkg::slc_scan_t               scan
);
    import slc_pkg::*;

    logic               have_empty_reg, have_empty_next;
    logic [WAY_W-1:0]   empty_way_reg, empty_way_next;
    logic [WAY_W-1:0]   lru_way_reg, lru_way_next;
    logic [STAMP_W-1:0] oldest_reg, oldest_next;
    logic               tag_eq;
    logic               older;

    assign tag_eq = (line_tag == key_tag);
    assign older  = (line_stamp < oldest_reg);

    always_comb begin
        have_empty_next = have_empty_reg;
        empty_way_next  = empty_way_reg;
        lru_way_next    = lru_way_reg;
        oldest_next     = oldest_reg;
        if (step) begin
            if (line_valid) begin
                if (!tag_eq && older) begin
                    oldest_next  = line_stamp;
                    lru_way_next = way;
                end
            end else if (!have_empty_reg) begin
                have_empty_next = 1'b1;
                empty_way_next  = way;
            end
        end
    end

    assign scan.hit        = step && line_valid && tag_eq;
    assign scan.have_empty = have_empty_next;
    assign scan.empty_way  = empty_way_next;
    assign scan.lru_way    = lru_way_next;

    // search starts from all ones, so way 0 wins when every stamp is all ones
    always_ff @(posedge aclk) begin
        if (clr) begin
            have_empty_reg <= 1'b0;
            empty_way_reg  <= '0;
            lru_way_reg    <= '0;
            oldest_reg     <= '1;
        end else begin
            have_empty_reg <= have_empty_next;
            empty_way_reg  <= empty_way_next;
            lru_way_reg    <= lru_way_next;
            oldest_reg     <= oldest_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/set_assoc_lru_cache_tags.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag store of a set-associative cache with LRU replacement and hit/miss totals.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Beat contents (low bit first)
//  s_       | in  | tdata: address[63:0]
//  m_       | out | tdata: hit, way_used[2:0], evicted, hit_total[31:0],
//           |     |        miss_total[31:0], 3 zero bits
//  cfg_     | in  | write: index 0 offset_bits, 1 index_bits, 2 ways_in_use
//
//  Each item is issued, scanned (up to all effective ways; a hit stops it),
//  updated and loaded out; the shared compare unit sees one way a cycle from
//  the tag array. A clearing pass over all 1024 valid rows follows reset and
//  keeps s_tready low. A result held on m_ stalls only the final load step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_lru_cache_tags_macros.svh"

module set_assoc_lru_cache_tags (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [slc_pkg::IN_DATA_W-1:0]     s_tdata,  // address
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [slc_pkg::OUT_DATA_W-1:0]    m_tdata,  // hit, way_used, evicted,
                                                             // hit_total, miss_total
    input  wire logic                              cfg_we,
    input  wire logic [slc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [slc_pkg::CFG_W-1:0]         cfg_wdata
);
    import slc_pkg::*;

    slc_state_t          state_reg, state_next;
    logic [CFG_W-1:0]    offset_bits_reg, index_bits_reg, ways_reg;
    logic [SET_W-1:0]    clr_row_reg;
    logic [SET_W-1:0]    set_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [CNT_W-1:0]    hit_cnt_reg, miss_cnt_reg;
    logic [WAY_W-1:0]    cmp_way_reg;
    logic [WAY_W-1:0]    target_reg;
    logic                hit_reg, evict_reg;
    logic                m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [CFG_W-1:0]    ib_eff;
    logic [CFG_W-1:0]    ways_eff;
    logic [CFG_W-1:0]    ways_m1_full;
    logic [WAY_W-1:0]    ways_m1;
    logic [SET_W-1:0]    set_mask;
    logic [ADDR_W-1:0]   addr_sh;
    logic [CFG_W:0]      tag_lsb;
    logic [WAY_W-1:0]    rd_way;
    logic                accept;
    logic                out_free;

    logic [TAG_W-1:0]    line_tag_rd;
    logic [STAMP_W-1:0]  line_stamp_rd;
    logic [MAX_WAYS-1:0] vrow_rd;
    slc_line_wr_t        line_wr;
    slc_vrow_wr_t        vrow_wr;
    slc_scan_t           scan;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // effective configuration
    assign ib_eff       = (index_bits_reg > IDX_BITS_LIM) ? IDX_BITS_LIM : index_bits_reg;
    assign ways_eff     = (ways_reg == '0) ? CFG_W'(1) :
                          ((ways_reg > WAYS_MAX) ? WAYS_MAX : ways_reg);
    assign ways_m1_full = ways_eff - CFG_W'(1);
    assign ways_m1      = ways_m1_full[WAY_W-1:0];

    // address split
    assign set_mask  = ~({SET_W{1'b1}} << ib_eff);
    assign addr_sh   = s_tdata >> offset_bits_reg;
    assign tag_lsb   = {1'b0, offset_bits_reg} + {1'b0, ib_eff};

    // way 0 is fetched in the issue step, then one ahead of the compare
    assign rd_way = (state_reg == S_ISSUE) ? '0 : cmp_way_reg + WAY_W'(1);

    slc_store u_store (
        .aclk          (aclk),
        .line_wr       (line_wr),
        .line_raddr    ({set_reg, rd_way}),
        .line_tag_rd   (line_tag_rd),
        .line_stamp_rd (line_stamp_rd),
        .vrow_wr       (vrow_wr),
        .vrow_raddr    (set_reg),
        .vrow_rd       (vrow_rd)
    );

    slc_way_cmp u_cmp (
        .aclk       (aclk),
        .clr        (state_reg == S_ISSUE),
        .step       (state_reg == S_SCAN),
        .way        (cmp_way_reg),
        .line_valid (vrow_rd[cmp_way_reg]),
        .line_tag   (line_tag_rd),
        .line_stamp (line_stamp_rd),
        .key_tag    (tag_reg),
        .scan       (scan)
    );

    always_comb begin
        line_wr.we    = (state_reg == S_UPDATE);
        line_wr.addr  = {set_reg, target_reg};
        line_wr.tag   = tag_reg;
        line_wr.stamp = stamp_reg;

        vrow_wr.we   = (state_reg == S_CLEAR) || (state_reg == S_UPDATE);
        vrow_wr.row  = (state_reg == S_CLEAR) ? clr_row_reg : set_reg;
        vrow_wr.bits = (state_reg == S_CLEAR) ? '0 :
                       (vrow_rd | (MAX_WAYS'(1) << target_reg));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_row_reg == {SET_W{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:  state_next = S_SCAN;
            S_SCAN: begin
                if (scan.hit || (cmp_way_reg == ways_m1)) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_row_reg     <= '0;
            offset_bits_reg <= RST_OFFSET_BITS;
            index_bits_reg  <= RST_INDEX_BITS;
            ways_reg        <= RST_WAYS;
            stamp_reg       <= '0;
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_row_reg <= clr_row_reg + SET_W'(1);
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_OFFSET_BITS: offset_bits_reg <= cfg_wdata;
                    REG_INDEX_BITS:  index_bits_reg  <= cfg_wdata;
                    REG_WAYS_IN_USE: ways_reg        <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                stamp_reg <= stamp_reg + STAMP_W'(1);
            end
            if (state_reg == S_UPDATE) begin
                if (hit_reg) begin
                    if (hit_cnt_reg != {CNT_W{1'b1}}) begin
                        hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                    end
                end else if (miss_cnt_reg != {CNT_W{1'b1}}) begin
                    miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
                end
            end
            if ((state_reg == S_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg <= addr_sh[SET_W-1:0] & set_mask;
            tag_reg <= s_tdata >> tag_lsb;
        end
        if (state_reg == S_ISSUE) begin
            cmp_way_reg <= '0;
        end else if (state_reg == S_SCAN) begin
            cmp_way_reg <= cmp_way_reg + WAY_W'(1);
            if (scan.hit) begin
                hit_reg    <= 1'b1;
                evict_reg  <= 1'b0;
                target_reg <= cmp_way_reg;
            end else if (cmp_way_reg == ways_m1) begin
                hit_reg    <= 1'b0;
                evict_reg  <= !scan.have_empty;
                target_reg <= scan.have_empty ? scan.empty_way : scan.lru_way;
            end
        end
        if ((state_reg == S_OUT) && out_free) begin
            m_tdata_reg <= {3'b000, miss_cnt_reg, hit_cnt_reg, evict_reg,
                            target_reg, hit_reg};
        end
    end

    `SLC_ASSERT(a_accept_to_issue, aclk, aresetn, accept |=> (state_reg == S_ISSUE))
    `SLC_NEVER(a_hit_no_evict, aclk, aresetn, m_tvalid_reg && m_tdata_reg[0] && m_tdata_reg[4])
    `SLC_ASSERT(a_cnt_hold, aclk, aresetn, ($past(aresetn) && ($past(state_reg) != S_UPDATE)) |-> ($stable(hit_cnt_reg) && $stable(miss_cnt_reg)))
    `SLC_ASSERT(a_scan_bound, aclk, aresetn, (state_reg == S_SCAN) |-> (cmp_way_reg <= ways_m1))

endmodule

`default_nettype wire

[tb/set_assoc_lru_cache_tags_test.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_test
// Self-checking bench for the LRU cache tag store. A short directed plan
// covers the field extremes, the clamped index and way counts and the
// reconfiguration of a live cache. It is followed by random phases that use a
// small pool of sets and tags, so hits, fills and LRU evictions all occur.
// Result beats are checked against an in-bench model or a typed plan row.
// Both streams idle at random.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_test;
    import slc_pkg::*;

    typedef struct packed {
        bit        hit;
        bit [2:0]  way;
        bit        evicted;
        bit [31:0] hits;
        bit [31:0] misses;
    } lookup_t;

    typedef struct packed {
        bit                 is_lookup;
        bit [63:0]          addr;
        bit [CFG_IDX_W-1:0] reg_idx;
        bit [CFG_W-1:0]     value;
        bit                 typed;
        lookup_t            want;
    } plan_row_t;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // decodes to no register
    localparam int IDLE_LIMIT     = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_LOOKUPS = 950;
    localparam bit [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam plan_row_t PLAN [0:30] = '{
        '{1'b1, 64'h0,     REG_OFFSET_BITS, 4'd0,  1'b1, '{1'b0, 3'd0, 1'b0, 32'd0, 32'd1}},
        '{1'b1, 64'h0,     REG_OFFSET_BITS, 4'd0,  1'b1, '{1'b1, 3'd0, 1'b0, 32'd1, 32'd1}},
        '{1'b1, ALL_ONES,  REG_OFFSET_BITS, 4'd0,  1'b1, '{1'b0, 3'd0, 1'b0, 32'd1, 32'd2}},
        '{1'b1, 64'h3F,    REG_OFFSET_BITS, 4'd0,  1'b1, '{1'b1, 3'd0, 1'b0, 32'd2, 32'd2}},
        // way count zero behaves as a direct-mapped cache
        '{1'b0, 64'h0,     REG_WAYS_IN_USE, 4'd0,  1'b0, '0},
        '{1'b1, 64'h1000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h0,     REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        // way count above the maximum clamps to eight; fill set 0, then evict
        '{1'b0, 64'h0,     REG_WAYS_IN_USE, 4'd15, 1'b0, '0},
        '{1'b1, 64'h1000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h2000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h3000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h4000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h5000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h6000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h7000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h8000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h1000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        // no offset, index count clamped to the set limit
        '{1'b0, 64'h0,     REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b0, 64'h0,     REG_INDEX_BITS,  4'd15, 1'b0, '0},
        '{1'b1, 64'h3FF,   REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h400,   REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, ALL_ONES,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        // widest offset, single set
        '{1'b0, 64'h0,     REG_OFFSET_BITS, 4'd15, 1'b0, '0},
        '{1'b0, 64'h0,     REG_INDEX_BITS,  4'd0,  1'b0, '0},
        '{1'b1, 64'h0,     REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h8000,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, ALL_ONES,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b0, 64'h0,     REG_SPARE,       4'd5,  1'b0, '0},
        '{1'b0, 64'h0,     REG_WAYS_IN_USE, 4'd9,  1'b0, '0},
        '{1'b1, 64'h7FFF,  REG_OFFSET_BITS, 4'd0,  1'b0, '0},
        '{1'b1, 64'h7FFF,  REG_OFFSET_BITS, 4'd0,  1'b0, '0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // address
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // hit, way_used[2:0], evicted, hit_total[31:0],
                                      // miss_total[31:0], 3 zero bits
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    set_assoc_lru_cache_tags dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // tag store model
    bit             line_ok    [MAX_SETS*MAX_WAYS];
    bit [63:0]      line_tag_q [MAX_SETS*MAX_WAYS];
    bit [63:0]      line_age   [MAX_SETS*MAX_WAYS];
    bit [63:0]      stamp_now;
    bit [31:0]      hit_run;
    bit [31:0]      miss_run;
    bit [CFG_W-1:0] off_cfg  = RST_OFFSET_BITS;
    bit [CFG_W-1:0] idx_cfg  = RST_INDEX_BITS;
    bit [CFG_W-1:0] ways_cfg = RST_WAYS;

    lookup_t expected_lookups [$];
    int      error_count;
    int      lookups_checked;
    int      hits_checked;
    int      evictions_checked;
    int      settings_used;
    int      idle_cycles;
    bit      send_quiet;
    bit      recv_quiet;

    function automatic int eff_index_bits();
        return (idx_cfg > IDX_BITS_LIM) ? int'(IDX_BITS_LIM) : int'(idx_cfg);
    endfunction

    function automatic lookup_t lookup_tags(input bit [63:0] addr);
        lookup_t   res;
        int        ib;
        int        ways;
        int        base;
        int        victim;
        int        empty_way;
        int        lru_way;
        bit        have_empty;
        bit [63:0] set_no;
        bit [63:0] tag;
        bit [63:0] oldest;
        ib = eff_index_bits();
        ways = (ways_cfg == 0) ? 1 : (ways_cfg > MAX_WAYS) ? MAX_WAYS : int'(ways_cfg);
        stamp_now++;
        set_no = (addr >> off_cfg) & ((64'd1 << ib) - 64'd1);
        tag = addr >> (off_cfg + ib);
        base = int'(set_no) * MAX_WAYS;
        oldest = '1;
        have_empty = 1'b0;
        empty_way = 0;
        lru_way = 0;
        for (int w = 0; w < ways; w++) begin
            if (line_ok[base+w]) begin
                if (line_tag_q[base+w] == tag) begin
                    line_age[base+w] = stamp_now;
                    if (hit_run != '1) hit_run++;
                    res = '{1'b1, 3'(w), 1'b0, hit_run, miss_run};
                    return res;
                end
                // strict compare: first way wins a tie
                if (line_age[base+w] < oldest) begin
                    oldest = line_age[base+w];
                    lru_way = w;
                end
            end else if (!have_empty) begin
                have_empty = 1'b1;
                empty_way = w;
            end
        end
        if (miss_run != '1) miss_run++;
        victim = have_empty ? empty_way : lru_way;
        line_ok[base+victim] = 1'b1;
        line_tag_q[base+victim] = tag;
        line_age[base+victim] = stamp_now;
        res = '{1'b0, 3'(victim), !have_empty, hit_run, miss_run};
        return res;
    endfunction

    function automatic bit [CFG_W-1:0] pick_setting();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return CFG_W'($urandom_range(0, 15));
        endcase
    endfunction

    // returns at the accepting edge with s_tvalid still high
    task automatic issue_lookup(input bit [63:0] addr);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_setting(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_OFFSET_BITS: off_cfg = val;
            REG_INDEX_BITS:  idx_cfg = val;
            REG_WAYS_IN_USE: ways_cfg = val;
            default: ;
        endcase
    endtask

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side: random back-pressure, compare against oldest expectation
    initial begin
        int      stall;
        lookup_t got;
        lookup_t want;
        @(posedge aclk);
        forever begin
            stall = recv_quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.hit = m_tdata[0];
            got.way = m_tdata[3:1];
            got.evicted = m_tdata[4];
            got.hits = m_tdata[36:5];
            got.misses = m_tdata[68:37];
            if (expected_lookups.size() == 0) begin
                $error("result beat with no lookup outstanding");
                error_count++;
            end else begin
                want = expected_lookups.pop_front();
                lookups_checked++;
                hits_checked += int'(want.hit);
                evictions_checked += int'(want.evicted);
                if (got.hit != want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    error_count++;
                end
                if (got.way != want.way) begin
                    $error("way_used: expected %0d, got %0d", want.way, got.way);
                    error_count++;
                end
                if (got.evicted != want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                    error_count++;
                end
                if (got.hits != want.hits) begin
                    $error("hit_total: expected %0d, got %0d", want.hits, got.hits);
                    error_count++;
                end
                if (got.misses != want.misses) begin
                    $error("miss_total: expected %0d, got %0d", want.misses, got.misses);
                    error_count++;
                end
            end
        end
    end

    // stops the run if neither stream moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("set_assoc_lru_cache_tags_test: done, errors");
            $finish;
        end
    end

    initial begin
        bit [63:0] pool_tag [12];
        bit [63:0] pool_set [4];
        bit [63:0] addr;
        lookup_t   predicted;
        int        eff_ib;
        int        n_sets;
        int        n_tags;
        int        phase_len;
        int        random_sent;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        idle_cycles <= 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (PLAN[r]) begin
            if (PLAN[r].is_lookup) begin
                issue_lookup(PLAN[r].addr);
                addr = PLAN[r].addr;
                // the model tracks every lookup, typed rows included
                predicted = lookup_tags(addr);
                expected_lookups.push_back(PLAN[r].typed ? PLAN[r].want : predicted);
            end else begin
                settle_block();
                write_setting(PLAN[r].reg_idx, PLAN[r].value);
                settings_used++;
            end
        end

        random_sent = 0;
        while (random_sent < RANDOM_LOOKUPS) begin
            settle_block();
            write_setting(REG_OFFSET_BITS, pick_setting());
            write_setting(REG_INDEX_BITS, pick_setting());
            write_setting(REG_WAYS_IN_USE, pick_setting());
            settings_used++;
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            // a few sets and tags per phase so lines get reused and evicted
            eff_ib = eff_index_bits();
            n_sets = $urandom_range(1, 4);
            n_tags = $urandom_range(1, 12);
            foreach (pool_set[k]) pool_set[k] = 64'($urandom_range(0, (1 << eff_ib) - 1));
            foreach (pool_tag[k]) pool_tag[k] = {$urandom, $urandom};
            phase_len = $urandom_range(40, 110);
            if (phase_len > RANDOM_LOOKUPS - random_sent) begin
                phase_len = RANDOM_LOOKUPS - random_sent;
            end
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < 80) begin
                    addr = (pool_tag[$urandom_range(0, n_tags - 1)] << (off_cfg + eff_ib))
                         | (pool_set[$urandom_range(0, n_sets - 1)] << off_cfg)
                         | ({$urandom, $urandom} & ((64'd1 << off_cfg) - 64'd1));
                end else begin
                    addr = {$urandom, $urandom};
                end
                issue_lookup(addr);
                expected_lookups.push_back(lookup_tags(addr));
                random_sent++;
            end
        end

        settle_block();
        $display("covered %0d lookups: %0d hits, %0d evictions, %0d settings",
                 lookups_checked, hits_checked, evictions_checked, settings_used);
        if (error_count == 0) begin
            $display("set_assoc_lru_cache_tags_test: done, clean");
        end else begin
            $display("set_assoc_lru_cache_tags_test: done, errors");
        end
        $finish;
    end

endmodule
